// File: rtl/uvs_pkg.sv
// Shared constants and types for the UV-sphere vertex generator.
// No dependencies; used by uvs_cordic and uv_sphere_vertex_generator_top.
`timescale 1ns / 1ps

package uvs_pkg;

  localparam int CORDIC_STEPS = 30;
  // Fold register, one register per rotation, sign-restore register, rounding register.
  localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
  localparam int PHASE_BITS   = 32;
  localparam int TEX_BITS     = 16;

  // Arctangent of 2^-i in turns, unsigned Q0.32.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Gain-compensated start value of the rotation, Q2.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_RADIUS   = 2'd0;
  localparam cfg_idx_t REG_SEGMENTS = 2'd1;
  localparam cfg_idx_t REG_INWARD   = 2'd2;

  localparam logic [15:0] RADIUS_RST   = 16'd256;
  localparam logic [8:0]  SEGMENTS_RST = 9'd32;

  // Fields that ride alongside the trigonometry pipeline.
  typedef struct packed {
    logic        oog;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

endpackage

// File: rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC: phase in turns to cosine and sine in Q1.F.
// Depends on uvs_pkg for the arctangent table, gain and step count.
`timescale 1ns / 1ps

module uvs_cordic #(
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic [31:0]                   phase,
  output logic signed [UNIT_FRAC_BITS+1:0] cos_val,
  output logic signed [UNIT_FRAC_BITS+1:0] sin_val
);

  localparam int UW = UNIT_FRAC_BITS + 2;
  localparam int XW = 34;
  localparam int N  = uvs_pkg::CORDIC_STEPS;
  localparam int SH = 30 - UNIT_FRAC_BITS;

  localparam logic [XW:0] HALF_U = ({{XW{1'b0}}, 1'b1} << SH) >> 1;
  localparam logic [XW:0] ONE_U  = {{XW{1'b0}}, 1'b1} << UNIT_FRAC_BITS;
  localparam logic signed [XW:0] RND_HALF = signed'(HALF_U);
  localparam logic signed [XW:0] UNIT_ONE = signed'(ONE_U);

  localparam logic signed [XW-1:0] TURN_QUARTER = 34'sd1073741824;
  localparam logic signed [XW-1:0] TURN_HALF    = 34'sd2147483648;

  logic signed [XW-1:0] x_r [0:N];
  logic signed [XW-1:0] y_r [0:N];
  logic signed [XW-1:0] z_r [0:N];
  logic                 flip_r [0:N];
  logic signed [XW-1:0] xf_r, yf_r;
  logic signed [UW-1:0] cos_r, sin_r;

  logic signed [XW-1:0] fold_a, fold_z;
  logic                 fold_flip;

  function automatic logic signed [UW-1:0] to_unit(input logic signed [XW-1:0] v);
    logic signed [XW:0] s;
    logic signed [XW:0] q;
    s = {v[XW-1], v} + RND_HALF;
    q = s >>> SH;
    if (q > UNIT_ONE) begin
      q = UNIT_ONE;
    end else if (q < -UNIT_ONE) begin
      q = -UNIT_ONE;
    end
    return UW'(q);
  endfunction

  // Bring the angle into a quarter turn either side of zero; a half-turn fold
  // negates both results at the end.
  always_comb begin
    fold_a    = XW'(signed'(phase));
    fold_z    = fold_a;
    fold_flip = 1'b0;
    priority if (fold_a > TURN_QUARTER) begin
      fold_z    = fold_a - TURN_HALF;
      fold_flip = 1'b1;
    end else if (fold_a < -TURN_QUARTER) begin
      fold_z    = fold_a + TURN_HALF;
      fold_flip = 1'b1;
    end else begin
      fold_z    = fold_a;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= uvs_pkg::CORDIC_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= fold_z;
    flip_r[0] <= fold_flip;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [XW-1:0] ATAN_I = signed'(XW'(uvs_pkg::ATAN_TURNS[i]));
    always_ff @(posedge clk) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_I;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_I;
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  always_ff @(posedge clk) begin
    xf_r  <= flip_r[N] ? -x_r[N] : x_r[N];
    yf_r  <= flip_r[N] ? -y_r[N] : y_r[N];
    cos_r <= to_unit(xf_r);
    sin_r <= to_unit(yf_r);
  end

  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

// File: rtl/uv_sphere_vertex_generator_top.sv
// Top level of the UV-sphere vertex generator: config registers, index dividers,
// normal and position arithmetic. Depends on uvs_pkg and uvs_cordic.
`timescale 1ns / 1ps

//  Channel   Ports                                   Handshake
//  input     in_ring_index, in_segment_index         start while busy low
//  result    out_pos_*, out_norm_*, out_tex_*,       out_strobe, one cycle
//            out_out_of_grid
//  config    cfg_index, cfg_data                     cfg_we, no wait
//
// One word enters per cycle; busy is never raised. A word's result passes through
// the input register, the 32-stage pipelined phase dividers, one quotient bit per
// stage, the 33-stage CORDIC pipes and four multiply, rounding and output stages
// before it is loaded into the output register.
// Reset loads the config registers with their defaults and clears every valid
// bit; the pipeline runs freely and the receiver cannot stall it.

module uv_sphere_vertex_generator_top #(
  parameter int MAX_SEGMENTS   = 256,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_ring_index,
  input  logic [8:0]         in_segment_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_strobe,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic               out_out_of_grid
);

  localparam int SW  = $clog2(MAX_SEGMENTS + 1);
  localparam int CW  = (SW > 9) ? SW : 9;
  localparam int UW  = UNIT_FRAC_BITS + 2;
  localparam int PW  = 2 * UW;
  localparam int RW  = UW + 17;
  localparam int PB  = uvs_pkg::PHASE_BITS;
  localparam int TB  = uvs_pkg::TEX_BITS;
  localparam int SD  = uvs_pkg::CORDIC_LAT + 3;
  localparam int LATENCY = PB + 2 + SD;

  localparam logic [PW-1:0] PHALF_U = {{(PW-1){1'b0}}, 1'b1} << (UNIT_FRAC_BITS - 1);
  localparam logic [RW-1:0] RHALF_U = {{(RW-1){1'b0}}, 1'b1} << (UNIT_FRAC_BITS - 1);

  typedef struct packed {
    logic [SW-1:0] rem_phi;
    logic [SW-1:0] rem_th;
    logic [SW-1:0] rem_u;
    logic [SW-1:0] rem_v;
    logic [31:0]   q_phi;
    logic [31:0]   q_th;
    logic [15:0]   q_u;
    logic [15:0]   q_v;
    logic          u_hi;
    logic          v_hi;
    logic          oog;
  } div_t;

  // Configuration registers.
  logic [15:0] radius_r;
  logic [8:0]  seg_cnt_r;
  logic        inward_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= uvs_pkg::RADIUS_RST;
      seg_cnt_r <= uvs_pkg::SEGMENTS_RST;
      inward_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::REG_RADIUS:   radius_r  <= cfg_data;
        uvs_pkg::REG_SEGMENTS: seg_cnt_r <= cfg_data[8:0];
        uvs_pkg::REG_INWARD:   inward_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective segment and ring counts.
  logic [CW-1:0] seg_ext, seg_clamp;
  logic [SW-1:0] s_eff, r_eff, half_r, d_th;
  logic [31:0]   lo_phi, lo_th;
  logic [15:0]   lo_u, lo_v;

  always_comb begin
    seg_ext = CW'(seg_cnt_r);
    priority if (seg_ext < CW'(2)) begin
      seg_clamp = CW'(2);
    end else if (seg_ext > CW'(MAX_SEGMENTS)) begin
      seg_clamp = CW'(MAX_SEGMENTS);
    end else begin
      seg_clamp = seg_ext;
    end
    s_eff  = SW'(seg_clamp);
    r_eff  = s_eff >> 1;
    half_r = r_eff >> 1;
    d_th   = SW'({r_eff, 1'b0});
    lo_phi = 32'(r_eff);
    lo_th  = 32'(r_eff);
    lo_u   = 16'(r_eff);
    lo_v   = 16'(half_r);
  end

  // Input stage: grid check and divider start values.
  logic          accept;
  logic [CW-1:0] ring_in, seg_in;
  logic          seg_full, ring_full;
  div_t          div_init;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ring_in   = CW'(in_ring_index);
    seg_in    = CW'(in_segment_index);
    seg_full  = (seg_in == CW'(s_eff));
    ring_full = (ring_in == CW'(r_eff));
    div_init  = '0;
    div_init.oog     = (ring_in > CW'(r_eff)) || (seg_in > CW'(s_eff));
    div_init.rem_phi = seg_full ? '0 : SW'(seg_in);
    div_init.rem_u   = seg_full ? '0 : SW'(seg_in);
    div_init.rem_th  = SW'(ring_in);
    div_init.rem_v   = ring_full ? '0 : SW'(ring_in);
    div_init.u_hi    = seg_full;
    div_init.v_hi    = ring_full;
  end

  // One restoring-division step: shift in a dividend bit, subtract if it fits.
  function automatic logic [SW:0] div_step(input logic [SW-1:0] rem, input logic din,
                                           input logic [SW-1:0] dvs);
    logic [SW:0] t;
    logic [SW:0] diff;
    t    = {rem, din};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, diff[SW-1:0]};
    end else begin
      return {1'b0, t[SW-1:0]};
    end
  endfunction

  div_t          div_r [0:PB];
  logic [PB:0]   div_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
    end else begin
      div_vld_r <= {div_vld_r[PB-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    div_r[0] <= div_init;
  end

  for (genvar k = 0; k < PB; k++) begin : g_div
    logic [SW:0]   st_phi, st_th;
    logic [SW-1:0] rem_u_nxt, rem_v_nxt;
    logic [15:0]   q_u_nxt, q_v_nxt;
    div_t          nxt;

    // The texture quotients need only the first sixteen steps.
    if (k < TB) begin : g_tex
      logic [SW:0] st_u, st_v;
      assign st_u      = div_step(div_r[k].rem_u, lo_u[TB-1-k], s_eff);
      assign st_v      = div_step(div_r[k].rem_v, lo_v[TB-1-k], r_eff);
      assign rem_u_nxt = st_u[SW-1:0];
      assign rem_v_nxt = st_v[SW-1:0];
      assign q_u_nxt   = {div_r[k].q_u[14:0], st_u[SW]};
      assign q_v_nxt   = {div_r[k].q_v[14:0], st_v[SW]};
    end else begin : g_hold
      assign rem_u_nxt = div_r[k].rem_u;
      assign rem_v_nxt = div_r[k].rem_v;
      assign q_u_nxt   = div_r[k].q_u;
      assign q_v_nxt   = div_r[k].q_v;
    end

    always_comb begin
      st_phi      = div_step(div_r[k].rem_phi, lo_phi[PB-1-k], s_eff);
      st_th       = div_step(div_r[k].rem_th, lo_th[PB-1-k], d_th);
      nxt         = div_r[k];
      nxt.rem_phi = st_phi[SW-1:0];
      nxt.q_phi   = {div_r[k].q_phi[30:0], st_phi[SW]};
      nxt.rem_th  = st_th[SW-1:0];
      nxt.q_th    = {div_r[k].q_th[30:0], st_th[SW]};
      nxt.rem_u   = rem_u_nxt;
      nxt.rem_v   = rem_v_nxt;
      nxt.q_u     = q_u_nxt;
      nxt.q_v     = q_v_nxt;
    end

    always_ff @(posedge clk) begin
      div_r[k+1] <= nxt;
    end
  end

  // Sine and cosine of both angles.
  logic signed [UW-1:0] cos_th, sin_th, cos_phi, sin_phi;

  uvs_cordic #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_cordic_th (
    .clk     (clk),
    .phase   (div_r[PB].q_th),
    .cos_val (cos_th),
    .sin_val (sin_th)
  );

  uvs_cordic #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_cordic_phi (
    .clk     (clk),
    .phase   (div_r[PB].q_phi),
    .cos_val (cos_phi),
    .sin_val (sin_phi)
  );

  // Grid flag and texture coordinates wait alongside the CORDIC and multipliers.
  uvs_pkg::side_t side_r [0:SD-1];
  logic [SD-1:0]  side_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_vld_r <= '0;
    end else begin
      side_vld_r <= {side_vld_r[SD-2:0], div_vld_r[PB]};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0].oog   <= div_r[PB].oog;
    side_r[0].tex_u <= {div_r[PB].u_hi, div_r[PB].q_u};
    side_r[0].tex_v <= {div_r[PB].v_hi, div_r[PB].q_v};
    for (int j = 1; j < SD; j++) begin
      side_r[j] <= side_r[j-1];
    end
  end

  // Normal and position arithmetic, pipelined over multiply, rounding and multiply stages.
  logic signed [PW-1:0] prod_x_r, prod_z_r;
  logic signed [UW-1:0] ny1_r;
  logic signed [UW-1:0] n2_r [0:2];
  logic signed [RW-1:0] pos_prod_r [0:2];
  logic signed [UW-1:0] n3_r [0:2];
  logic signed [16:0]   rad_s;

  assign rad_s = signed'({1'b0, radius_r});

  always_ff @(posedge clk) begin
    prod_x_r <= sin_th * cos_phi;
    prod_z_r <= sin_th * sin_phi;
    ny1_r    <= cos_th;
    n2_r[0]  <= UW'((prod_x_r + signed'(PHALF_U)) >>> UNIT_FRAC_BITS);
    n2_r[1]  <= ny1_r;
    n2_r[2]  <= UW'((prod_z_r + signed'(PHALF_U)) >>> UNIT_FRAC_BITS);
    for (int a = 0; a < 3; a++) begin
      pos_prod_r[a] <= rad_s * n2_r[a];
      n3_r[a]       <= n2_r[a];
    end
  end

  // Output register.
  logic                 strobe_r;
  logic signed [16:0]   pos_r [0:2];
  logic signed [15:0]   norm_r [0:2];
  logic [16:0]          tex_u_r, tex_v_r;
  logic                 oog_r;
  logic                 oog_last;

  assign oog_last = side_r[SD-1].oog;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= side_vld_r[SD-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      pos_r[a]  <= oog_last ? '0 :
                   17'((pos_prod_r[a] + signed'(RHALF_U)) >>> UNIT_FRAC_BITS);
      norm_r[a] <= oog_last ? '0 : (inward_r ? 16'(-n3_r[a]) : 16'(n3_r[a]));
    end
    tex_u_r <= oog_last ? '0 : side_r[SD-1].tex_u;
    tex_v_r <= oog_last ? '0 : side_r[SD-1].tex_v;
    oog_r   <= oog_last;
  end

  assign out_strobe      = strobe_r;
  assign out_pos_x       = pos_r[0];
  assign out_pos_y       = pos_r[1];
  assign out_pos_z       = pos_r[2];
  assign out_norm_x      = norm_r[0];
  assign out_norm_y      = norm_r[1];
  assign out_norm_z      = norm_r[2];
  assign out_tex_u       = tex_u_r;
  assign out_tex_v       = tex_v_r;
  assign out_out_of_grid = oog_r;

  // Every accepted word comes out exactly after the fixed pipeline latency.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("accepted word did not emerge after the pipeline latency");

  // An out-of-grid word carries all-zero payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_out_of_grid) |->
      (out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0 && out_norm_x == 0 &&
       out_norm_y == 0 && out_norm_z == 0 && out_tex_u == 0 && out_tex_v == 0))
    else $error("out-of-grid word has nonzero payload");

  // Texture coordinates never exceed one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_tex_u <= 17'd65536 && out_tex_v <= 17'd65536))
    else $error("texture coordinate above one");

endmodule
